[src/mexp_pkg.sv]
// ----------------------------------------------------------------------------
// mexp_pkg: shared definitions for the modular exponentiation block
// Operand width, stream widths, register indexes, controller states, the
// command and status groups between controller and datapath, and the
// modular add used by the shift-and-add multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package mexp_pkg;

  localparam int OPERAND_WIDTH = 64;
  localparam int TDATA_W       = ((OPERAND_WIDTH + 7) / 8) * 8;
  localparam int CNT_W         = $clog2(OPERAND_WIDTH);
  localparam int CFG_INDEX_W   = 2;

  typedef logic [OPERAND_WIDTH-1:0] operand_t;
  typedef logic [CFG_INDEX_W-1:0]   cfg_index_t;
  typedef logic [CNT_W-1:0]         bit_cnt_t;

  localparam cfg_index_t REG_KEY_EXPONENT = cfg_index_t'(0);
  localparam cfg_index_t REG_KEY_MODULUS  = cfg_index_t'(1);

  localparam bit_cnt_t LAST_BIT = bit_cnt_t'(OPERAND_WIDTH - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_LOOP,
    ST_START,
    ST_DOUBLE,
    ST_ADD,
    ST_COMMIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;       // capture base and exponent, res = 1
    logic red_step;   // one restoring step of base mod modulus
    logic red_last;   // last reduction step: write remainder to base
    logic mul_start;  // clear accumulators, copy base to multiplier bits
    logic mul_dbl;    // accumulators doubled mod m
    logic mul_add;    // conditional add of multiplicand mod m
    logic commit;     // take square and (if exponent bit set) product
    logic out_load;   // move result into output register
  } dp_cmd_t;

  typedef struct packed {
    logic m_zero;
    logic m_small;    // modulus is zero or one
    logic e_zero;
    logic e_lsb;
  } dp_status_t;

  // (a + b) mod m for a, b < m
  function automatic operand_t add_mod(operand_t a, operand_t b, operand_t m);
    logic [OPERAND_WIDTH:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= {1'b0, m}) begin
      sum = sum - {1'b0, m};
    end
    return sum[OPERAND_WIDTH-1:0];
  endfunction

endpackage

`default_nettype wire

[src/modular_exponentiation.sv]
// ----------------------------------------------------------------------------
// modular_exponentiation: base ^ key_exponent mod key_modulus
// Right-to-left square-and-multiply with bit-serial modular multipliers.
// ----------------------------------------------------------------------------
// One base is taken at a time and gives one result. After the base transfer
// the block reduces the base (one restoring step per cycle), then handles
// each exponent bit up to the highest set bit: the square and the product
// run side by side, each doubling and conditionally adding mod m in
// alternate cycles. A modulus of zero or one skips the reduction and the
// loop and gives result 0; zero also sets the error flag in out_tuser. The
// result sits in an output register; the next base is taken once the block
// is back in idle.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_exponentiation (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  input  wire [mexp_pkg::TDATA_W-1:0]  in_tdata,   // [63:0] base_value
  output logic                         out_tvalid,
  input  wire                          out_tready,
  output logic [mexp_pkg::TDATA_W-1:0] out_tdata,  // [63:0] power_result
  output logic                         out_tuser,  // [0] modulus_error
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire mexp_pkg::cfg_index_t    cfg_index,
  input  wire mexp_pkg::operand_t      cfg_data
);
  import mexp_pkg::*;

  operand_t   key_exponent;
  operand_t   key_modulus;
  operand_t   out_result;
  dp_cmd_t    cmd;
  dp_status_t status;

  mexp_regs u_regs (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .key_exponent (key_exponent),
    .key_modulus  (key_modulus)
  );

  mexp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  mexp_dp u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .key_exponent (key_exponent),
    .key_modulus  (key_modulus),
    .base_value   (in_tdata[OPERAND_WIDTH-1:0]),
    .status       (status),
    .out_result   (out_result),
    .out_error    (out_tuser)
  );

  assign out_tdata = TDATA_W'(out_result);

endmodule

`default_nettype wire

[src/mexp_regs.sv]
// ----------------------------------------------------------------------------
// mexp_regs: key register file
// Holds key exponent and key modulus, written through the config channel.
// Writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_regs (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     cfg_valid,
  output logic                    cfg_ready,
  input  wire mexp_pkg::cfg_index_t cfg_index,
  input  wire mexp_pkg::operand_t cfg_data,
  output mexp_pkg::operand_t      key_exponent,
  output mexp_pkg::operand_t      key_modulus
);
  import mexp_pkg::*;

  operand_t key_exponent_r, key_exponent_nxt;
  operand_t key_modulus_r,  key_modulus_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    key_exponent_nxt = key_exponent_r;
    key_modulus_nxt  = key_modulus_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_KEY_EXPONENT: key_exponent_nxt = cfg_data;
        REG_KEY_MODULUS:  key_modulus_nxt  = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_exponent_r <= operand_t'(1);
      key_modulus_r  <= operand_t'(1);
    end else begin
      key_exponent_r <= key_exponent_nxt;
      key_modulus_r  <= key_modulus_nxt;
    end
  end

  assign key_exponent = key_exponent_r;
  assign key_modulus  = key_modulus_r;

endmodule

`default_nettype wire

[src/mexp_ctrl.sv]
// ----------------------------------------------------------------------------
// mexp_ctrl: sequencer for square-and-multiply
// Steps the datapath through base reduction, one bit-serial square and
// multiply per exponent bit, and the hand-off into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_ctrl (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_tvalid,
  output logic                    in_tready,
  output logic                    out_tvalid,
  input  wire                     out_tready,
  input  wire mexp_pkg::dp_status_t status,
  output mexp_pkg::dp_cmd_t       cmd
);
  import mexp_pkg::*;

  state_t   state_r, state_nxt;
  bit_cnt_t cnt_r, cnt_nxt;
  logic     out_valid_r, out_valid_nxt;
  logic     out_free;

  assign out_free = !out_valid_r || out_tready;

  // next state and bit counter
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cnt_nxt   = LAST_BIT;
          state_nxt = status.m_small ? ST_FINISH : ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        cnt_nxt = cnt_r - bit_cnt_t'(1);
        if (cnt_r == '0) begin
          state_nxt = ST_LOOP;
        end
      end
      ST_LOOP: begin
        state_nxt = status.e_zero ? ST_FINISH : ST_START;
      end
      ST_START: begin
        cnt_nxt   = LAST_BIT;
        state_nxt = ST_DOUBLE;
      end
      ST_DOUBLE: begin
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        cnt_nxt = cnt_r - bit_cnt_t'(1);
        state_nxt = (cnt_r == '0) ? ST_COMMIT : ST_DOUBLE;
      end
      ST_COMMIT: begin
        state_nxt = ST_LOOP;
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd           = '0;
    in_tready     = (state_r == ST_IDLE);
    cmd.load      = (state_r == ST_IDLE) && in_tvalid;
    cmd.red_step  = (state_r == ST_REDUCE);
    cmd.red_last  = (state_r == ST_REDUCE) && (cnt_r == '0);
    cmd.mul_start = (state_r == ST_START);
    cmd.mul_dbl   = (state_r == ST_DOUBLE);
    cmd.mul_add   = (state_r == ST_ADD);
    cmd.commit    = (state_r == ST_COMMIT);
    cmd.out_load  = (state_r == ST_FINISH) && out_free;
  end

  // hold the result until the downstream transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

[src/mexp_dp.sv]
// ----------------------------------------------------------------------------
// mexp_dp: modular exponentiation datapath
// Restoring reduction of the base, two shift-and-add modular multipliers
// (square and product) that share the multiplier bits, exponent shifter
// and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_dp (
  input  wire                  clk,
  input  wire mexp_pkg::dp_cmd_t cmd,
  input  wire mexp_pkg::operand_t key_exponent,
  input  wire mexp_pkg::operand_t key_modulus,
  input  wire mexp_pkg::operand_t base_value,
  output mexp_pkg::dp_status_t status,
  output mexp_pkg::operand_t   out_result,
  output logic                 out_error
);
  import mexp_pkg::*;

  operand_t e_r, e_nxt;
  operand_t b_r, b_nxt;
  operand_t rem_r, rem_nxt;
  operand_t res_r, res_nxt;
  operand_t q_r, q_nxt;
  operand_t acc_sq_r, acc_sq_nxt;
  operand_t acc_mu_r, acc_mu_nxt;
  operand_t out_result_r, out_result_nxt;
  logic     out_error_r, out_error_nxt;

  logic [OPERAND_WIDTH:0] rem_shift;
  logic [OPERAND_WIDTH:0] rem_red;
  logic                   m_small;

  assign m_small = (key_modulus[OPERAND_WIDTH-1:1] == '0);

  always_comb begin
    rem_shift = {rem_r, b_r[OPERAND_WIDTH-1]};
    rem_red   = rem_shift;
    if (rem_shift >= {1'b0, key_modulus}) begin
      rem_red = rem_shift - {1'b0, key_modulus};
    end
  end

  always_comb begin
    e_nxt          = e_r;
    b_nxt          = b_r;
    rem_nxt        = rem_r;
    res_nxt        = res_r;
    q_nxt          = q_r;
    acc_sq_nxt     = acc_sq_r;
    acc_mu_nxt     = acc_mu_r;
    out_result_nxt = out_result_r;
    out_error_nxt  = out_error_r;

    if (cmd.load) begin
      e_nxt   = key_exponent;
      b_nxt   = base_value;
      rem_nxt = '0;
      res_nxt = operand_t'(1);
    end
    if (cmd.red_step) begin
      rem_nxt = rem_red[OPERAND_WIDTH-1:0];
      b_nxt   = cmd.red_last ? rem_red[OPERAND_WIDTH-1:0] : (b_r << 1);
    end
    if (cmd.mul_start) begin
      acc_sq_nxt = '0;
      acc_mu_nxt = '0;
      q_nxt      = b_r;
    end
    if (cmd.mul_dbl) begin
      acc_sq_nxt = add_mod(acc_sq_r, acc_sq_r, key_modulus);
      acc_mu_nxt = add_mod(acc_mu_r, acc_mu_r, key_modulus);
    end
    if (cmd.mul_add) begin
      if (q_r[OPERAND_WIDTH-1]) begin
        acc_sq_nxt = add_mod(acc_sq_r, b_r, key_modulus);
        acc_mu_nxt = add_mod(acc_mu_r, res_r, key_modulus);
      end
      q_nxt = q_r << 1;
    end
    if (cmd.commit) begin
      b_nxt = acc_sq_r;
      if (e_r[0]) begin
        res_nxt = acc_mu_r;
      end
      e_nxt = e_r >> 1;
    end
    if (cmd.out_load) begin
      out_result_nxt = m_small ? '0 : res_r;
      out_error_nxt  = (key_modulus == '0);
    end
  end

  always_ff @(posedge clk) begin
    e_r          <= e_nxt;
    b_r          <= b_nxt;
    rem_r        <= rem_nxt;
    res_r        <= res_nxt;
    q_r          <= q_nxt;
    acc_sq_r     <= acc_sq_nxt;
    acc_mu_r     <= acc_mu_nxt;
    out_result_r <= out_result_nxt;
    out_error_r  <= out_error_nxt;
  end

  always_comb begin
    status.m_zero  = (key_modulus == '0);
    status.m_small = m_small;
    status.e_zero  = (e_r == '0);
    status.e_lsb   = e_r[0];
  end

  assign out_result = out_result_r;
  assign out_error  = out_error_r;

endmodule

`default_nettype wire

[src/mexp_checker.sv]
// ----------------------------------------------------------------------------
// mexp_checker: port-level checks for modular_exponentiation
// Output hold under backpressure, error results carry zero data, and the
// block goes busy after each base transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_checker (
  input wire                         clk,
  input wire                         rst_n,
  input wire                         in_tvalid,
  input wire                         in_tready,
  input wire                         out_tvalid,
  input wire                         out_tready,
  input wire [mexp_pkg::TDATA_W-1:0] out_tdata,
  input wire                         out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("error result with nonzero data");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("new base taken while one is in work");

endmodule

bind modular_exponentiation mexp_checker u_chk (.*);

`default_nettype wire

[bench/tb_modular_exponentiation.sv]
// ----------------------------------------------------------------------------
// tb_modular_exponentiation: self-checking bench for the exponentiation block
// Walks a table of key writes and bases with hand-worked answers for the
// corner cases, then runs random key phases, most with short exponents and a
// few with full-width ones. Every result is checked in order, against the
// typed answer or a 128-bit wide square-and-multiply predictor, with random
// stalls on both streams.
// ----------------------------------------------------------------------------
module tb_modular_exponentiation;
  import mexp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int unsigned TAIL_CYCLES = 9000;
  localparam int unsigned RANDOM_BASES = 84;

  localparam operand_t   ALL_ONES        = '1;
  localparam cfg_index_t REG_UNMAPPED_LO = cfg_index_t'(2);
  localparam cfg_index_t REG_UNMAPPED_HI = cfg_index_t'(3);

  typedef enum logic [1:0] {
    KIND_WRITE,  // key register write
    KIND_BASE,   // base, answer from the predictor
    KIND_KNOWN   // base with answer typed in the row
  } row_kind_t;

  typedef struct packed {
    operand_t power;
    logic     error;
  } mexp_result_t;

  typedef struct packed {
    row_kind_t  kind;
    cfg_index_t index;
    operand_t   value;
    operand_t   power;
    logic       error;
  } vector_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [TDATA_W-1:0]   in_tdata   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [TDATA_W-1:0]   out_tdata;  // [63:0] power_result
  logic                 out_tuser;  // [0] modulus_error
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  cfg_index_t           cfg_index  = '0;
  operand_t             cfg_data   = '0;

  operand_t     key_exponent = operand_t'(1);
  operand_t     key_modulus  = operand_t'(1);
  mexp_result_t pending_powers [$];
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count = 0;

  vector_t directed_rows [28] = '{
    '{KIND_KNOWN, REG_KEY_EXPONENT, 64'h3039,     64'd0, 1'b0},
    '{KIND_KNOWN, REG_KEY_EXPONENT, ALL_ONES,     64'd0, 1'b0},
    '{KIND_WRITE, REG_KEY_MODULUS,  64'd0,        64'd0, 1'b0},
    '{KIND_KNOWN, REG_KEY_EXPONENT, 64'd7,        64'd0, 1'b1},
    '{KIND_KNOWN, REG_KEY_EXPONENT, ALL_ONES,     64'd0, 1'b1},
    '{KIND_WRITE, REG_KEY_MODULUS,  64'd13,       64'd0, 1'b0},
    '{KIND_WRITE, REG_KEY_EXPONENT, 64'd0,        64'd0, 1'b0},
    '{KIND_KNOWN, REG_KEY_EXPONENT, 64'd5,        64'd1, 1'b0},
    '{KIND_KNOWN, REG_KEY_EXPONENT, 64'd0,        64'd1, 1'b0},
    '{KIND_WRITE, REG_KEY_EXPONENT, 64'd1,        64'd0, 1'b0},
    '{KIND_KNOWN, REG_KEY_EXPONENT, 64'd20,       64'd7, 1'b0},
    '{KIND_BASE,  REG_KEY_EXPONENT, ALL_ONES,     64'd0, 1'b0},
    '{KIND_WRITE, REG_UNMAPPED_LO,  ALL_ONES,     64'd0, 1'b0},
    '{KIND_WRITE, REG_UNMAPPED_HI,  64'd5,        64'd0, 1'b0},
    '{KIND_KNOWN, REG_KEY_EXPONENT, 64'd13,       64'd0, 1'b0},
    '{KIND_WRITE, REG_KEY_MODULUS,  ALL_ONES,     64'd0, 1'b0},
    '{KIND_WRITE, REG_KEY_EXPONENT, ALL_ONES,     64'd0, 1'b0},
    '{KIND_KNOWN, REG_KEY_EXPONENT, ALL_ONES,     64'd0, 1'b0},
    '{KIND_BASE,  REG_KEY_EXPONENT, 64'd2,        64'd0, 1'b0},
    '{KIND_WRITE, REG_KEY_EXPONENT, 64'd2,        64'd0, 1'b0},
    '{KIND_KNOWN, REG_KEY_EXPONENT, 64'd3,        64'd9, 1'b0},
    '{KIND_BASE,  REG_KEY_EXPONENT, 64'h8000_0000_0000_0001, 64'd0, 1'b0},
    '{KIND_WRITE, REG_KEY_MODULUS,  64'd2,        64'd0, 1'b0},
    '{KIND_KNOWN, REG_KEY_EXPONENT, ALL_ONES,     64'd1, 1'b0},
    '{KIND_WRITE, REG_KEY_MODULUS,  64'd1000000007, 64'd0, 1'b0},
    '{KIND_WRITE, REG_KEY_EXPONENT, 64'd65537,    64'd0, 1'b0},
    '{KIND_BASE,  REG_KEY_EXPONENT, 64'd2,        64'd0, 1'b0},
    '{KIND_BASE,  REG_KEY_EXPONENT, ALL_ONES,     64'd0, 1'b0}
  };

  modular_exponentiation dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic operand_t product_mod(operand_t a, operand_t b, operand_t modulus);
    logic [2*OPERAND_WIDTH-1:0] wide;
    wide = {{OPERAND_WIDTH{1'b0}}, a} * {{OPERAND_WIDTH{1'b0}}, b};
    wide = wide % {{OPERAND_WIDTH{1'b0}}, modulus};
    return wide[OPERAND_WIDTH-1:0];
  endfunction

  function automatic mexp_result_t predict_power(operand_t base, operand_t exponent,
                                                 operand_t modulus);
    mexp_result_t res;
    operand_t     acc;
    operand_t     square;
    res = '0;
    if (modulus == '0) begin
      res.error = 1'b1;
    end else if (modulus != operand_t'(1)) begin
      acc    = operand_t'(1);
      square = base % modulus;
      for (int i = 0; i < OPERAND_WIDTH; i++) begin
        if (exponent[i]) begin
          acc = product_mod(acc, square, modulus);
        end
        square = product_mod(square, square, modulus);
      end
      res.power = acc;
    end
    return res;
  endfunction

  function automatic operand_t rand_operand(int unsigned width);
    operand_t v;
    v = {$urandom, $urandom};
    return (width >= OPERAND_WIDTH) ? v : (v >> (OPERAND_WIDTH - width));
  endfunction

  // mostly back-to-back or short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 4);
    end
    return $urandom_range(20, 200);
  endfunction

  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (pending_powers.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // called at a falling edge; hold valid until the transfer, then drop it
  task automatic send_base(operand_t base, logic typed, mexp_result_t typed_result);
    mexp_result_t expected;
    in_tdata  = TDATA_W'(base);
    in_tvalid = 1'b1;
    do begin
      @(posedge clk);
    end while (!in_tready);
    expected = typed ? typed_result : predict_power(base, key_exponent, key_modulus);
    pending_powers = {pending_powers, expected};
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic write_key(cfg_index_t index, operand_t value);
    wait_drained();
    cfg_index = index;
    cfg_data  = value;
    cfg_valid = 1'b1;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    if (index == REG_KEY_EXPONENT) begin
      key_exponent = value;
    end else if (index == REG_KEY_MODULUS) begin
      key_modulus = value;
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic operand_t pick_modulus();
    int unsigned r;
    r = $urandom_range(0, 19);
    case (r)
      0: return '0;
      1: return operand_t'(1);
      2: return operand_t'(2);
      3: return ALL_ONES;
      4, 5, 6, 7: return rand_operand($urandom_range(2, 16));
      8, 9, 10, 11: return rand_operand($urandom_range(17, 63));
      default: return rand_operand(OPERAND_WIDTH);
    endcase
  endfunction

  function automatic operand_t pick_base(operand_t modulus);
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0: return '0;
      1: return modulus - operand_t'(1);
      2: return modulus;
      3: return ALL_ONES;
      4: return rand_operand(8);
      default: return rand_operand(OPERAND_WIDTH);
    endcase
  endfunction

  // receiver: ready most cycles, short stalls, rare long stalls, calm stretches
  initial begin
    int unsigned stall_left;
    int unsigned calm_left;
    int unsigned r;
    stall_left = 0;
    calm_left  = 0;
    forever begin
      @(negedge clk);
      if (calm_left != 0) begin
        calm_left--;
        out_tready = 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        out_tready = 1'b0;
      end else begin
        r = $urandom_range(0, 999);
        out_tready = 1'b1;
        if (r < 300) begin
          out_tready = 1'b0;
          stall_left = $urandom_range(0, 4);
        end else if (r < 330) begin
          out_tready = 1'b0;
          stall_left = $urandom_range(20, 300);
        end else if (r < 335) begin
          calm_left = $urandom_range(500, 3000);
        end
      end
    end
  end

  always @(posedge clk) begin
    mexp_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_powers.size() == 0) begin
        $display("%0t: unexpected result transfer power=%h error=%b",
                 $time, out_tdata, out_tuser);
        mismatch_count++;
      end else begin
        want = pending_powers.pop_front();
        if (out_tdata[OPERAND_WIDTH-1:0] !== want.power) begin
          $display("%0t: power_result expected %h actual %h",
                   $time, want.power, out_tdata[OPERAND_WIDTH-1:0]);
          mismatch_count++;
        end
        if (out_tuser !== want.error) begin
          $display("%0t: modulus_error expected %b actual %b",
                   $time, want.error, out_tuser);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout with %0d results outstanding", $time, pending_powers.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int unsigned  bases_left;
    int unsigned  phase_len;
    logic         long_key;
    operand_t     next_exponent;
    operand_t     next_modulus;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i]) begin
      repeat (pick_gap()) @(negedge clk);
      if (directed_rows[i].kind == KIND_WRITE) begin
        write_key(directed_rows[i].index, directed_rows[i].value);
      end else begin
        send_base(directed_rows[i].value, directed_rows[i].kind == KIND_KNOWN,
                  '{power: directed_rows[i].power, error: directed_rows[i].error});
      end
    end

    bases_left = RANDOM_BASES;
    while (bases_left != 0) begin
      // new key phase: full-width exponents are slow, so keep them rare and short
      long_key     = ($urandom_range(0, 5) == 0);
      next_modulus = pick_modulus();
      if (long_key) begin
        next_exponent = rand_operand(OPERAND_WIDTH) | {1'b1, {(OPERAND_WIDTH-1){1'b0}}};
        phase_len     = $urandom_range(1, 3);
      end else begin
        case ($urandom_range(0, 9))
          0: next_exponent = '0;
          1: next_exponent = operand_t'(1);
          default: next_exponent = rand_operand($urandom_range(1, 10));
        endcase
        phase_len = $urandom_range(6, 14);
      end
      if ($urandom_range(0, 5) == 0) begin
        write_key($urandom_range(0, 1) ? REG_UNMAPPED_LO : REG_UNMAPPED_HI,
                  rand_operand(OPERAND_WIDTH));
      end
      if ($urandom_range(0, 1) != 0) begin
        write_key(REG_KEY_MODULUS, next_modulus);
        if ($urandom_range(0, 4) != 0 || long_key) begin
          write_key(REG_KEY_EXPONENT, next_exponent);
        end
      end else begin
        write_key(REG_KEY_EXPONENT, next_exponent);
        if ($urandom_range(0, 4) != 0) begin
          write_key(REG_KEY_MODULUS, next_modulus);
        end
      end

      while (phase_len != 0 && bases_left != 0) begin
        if ($urandom_range(0, 11) == 0) begin
          wait_drained();
        end
        repeat (pick_gap()) @(negedge clk);
        send_base(pick_base(key_modulus), 1'b0, '0);
        phase_len--;
        bases_left--;
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && pending_powers.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
